>>> hdl/bsrs_pkg.sv
// Shared types and constants for the button shift-register scanner.
// No dependencies; imported by every module of the block.
package bsrs_pkg;

    localparam int NUM_BITS_DEF = 8;   // default scan width
    localparam int NUM_BUTTONS  = 8;   // ids are configured for eight buttons
    localparam int LEVEL_W      = 8;   // width of one raw poll
    localparam int BTN_IDX_W    = 3;   // selects one of the eight ids
    localparam int ID_W         = 16;
    localparam int IDS_PER_WORD = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDS_LOW      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDS_HIGH     = 4'd3;

    // event kinds
    localparam logic KIND_DOWN = 1'b0;
    localparam logic KIND_UP   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT_ID,
        ST_EMIT_ANY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // poll request taken this cycle
        logic advance;   // any-key copy taken, drop current button
        logic sel_any;   // present the any-key copy (id 0)
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic load_events;  // poll on the input would produce events
        logic pending;      // buttons left to report
        logic more;         // more than one button left
    } dp_status_t;

endpackage

>>> hdl/bsrs_ctrl.sv
// Sequencer of the button scanner: takes a poll request, then walks the
// event pair (id, any-key) per changed button. Depends on bsrs_pkg.
module bsrs_ctrl
    import bsrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       last,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        last        = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.load_events)
                    begin
                        state_next = ST_EMIT_ID;
                    end
                end
            end
            ST_EMIT_ID:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_EMIT_ANY;
                end
            end
            ST_EMIT_ANY:
            begin
                out_valid   = 1'b1;
                cmd.sel_any = 1'b1;
                last        = !status.more;
                if (!out_stall)
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.more ? ST_EMIT_ID : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/bsrs_datapath.sv
// Datapath of the button scanner: configuration registers, stored levels,
// pending-event mask and result fields. Depends on bsrs_pkg.
module bsrs_datapath
    import bsrs_pkg::*;
#(
    parameter int NUM_BITS = NUM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [LEVEL_W-1:0]    raw_levels,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  event_kind,
    output logic [ID_W-1:0]       button_id
);

    localparam int ScanW = (NUM_BITS > NUM_BUTTONS) ? NUM_BUTTONS :
                           ((NUM_BITS < 1) ? 1 : NUM_BITS);

    logic                  scan_enable_reg;
    logic [LEVEL_W-1:0]    invert_mask_reg;
    logic [CFG_DATA_W-1:0] ids_low_reg;
    logic [CFG_DATA_W-1:0] ids_high_reg;

    logic [ScanW-1:0] levels_reg, levels_next;
    logic [ScanW-1:0] now_reg, now_next;
    logic [ScanW-1:0] mask_reg, mask_next;

    logic [ID_W-1:0]      ids [NUM_BUTTONS];
    logic [LEVEL_W-1:0]   raw_x;
    logic [ScanW-1:0]     now_w;
    logic [ScanW-1:0]     id_nz;
    logic [ScanW-1:0]     load_mask;
    logic [ScanW-1:0]     mask_rest;
    logic [ScanW-1:0]     low_hot;
    logic [BTN_IDX_W-1:0] sel_idx;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg <= 1'b1;
            invert_mask_reg <= '0;
            ids_low_reg     <= '0;
            ids_high_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCAN_ENABLE: scan_enable_reg <= cfg_data[0];
                REG_INVERT_MASK: invert_mask_reg <= cfg_data[LEVEL_W-1:0];
                REG_IDS_LOW:     ids_low_reg     <= cfg_data;
                REG_IDS_HIGH:    ids_high_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (b < IDS_PER_WORD)
            begin
                ids[b] = ids_low_reg[ID_W*b +: ID_W];
            end
            else
            begin
                ids[b] = ids_high_reg[ID_W*(b-IDS_PER_WORD) +: ID_W];
            end
        end
    end

    assign raw_x = raw_levels ^ invert_mask_reg;
    assign now_w = raw_x[ScanW-1:0];

    always_comb
    begin
        for (int b = 0; b < ScanW; b++)
        begin
            id_nz[b] = (ids[b] != '0);
        end
    end

    assign load_mask = scan_enable_reg ? ((now_w ^ levels_reg) & id_nz) : '0;
    assign mask_rest = mask_reg & (mask_reg - ScanW'(1));
    assign low_hot   = mask_reg & ~mask_rest;

    // lowest pending button
    always_comb
    begin
        sel_idx = '0;
        for (int b = ScanW - 1; b >= 0; b--)
        begin
            if (mask_reg[b])
            begin
                sel_idx = BTN_IDX_W'(b);
            end
        end
    end

    always_comb
    begin
        levels_next = levels_reg;
        now_next    = now_reg;
        mask_next   = mask_reg;
        if (cmd.load)
        begin
            mask_next = load_mask;
            now_next  = now_w;
            if (scan_enable_reg)
            begin
                levels_next = now_w;
            end
        end
        else if (cmd.advance)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
            mask_reg   <= '0;
        end
        else
        begin
            levels_reg <= levels_next;
            mask_reg   <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
    end

    assign status.load_events = (load_mask != '0);
    assign status.pending     = (mask_reg != '0);
    assign status.more        = (mask_rest != '0);

    // rising level -> key down
    assign event_kind = ((now_reg & low_hot) != '0) ? KIND_DOWN : KIND_UP;
    assign button_id  = cmd.sel_any ? '0 : ids[sel_idx];

endmodule

>>> hdl/button_shift_register_scanner_core.sv
// Button scanner: takes polls of the eight levels read from an external
// parallel-in serial-out register (first shifted bit in bit 7), applies the
// invert mask, compares with the stored levels and reports each changed
// button with a nonzero id as a key-down (0->1) or key-up (1->0) event,
// followed by an any-key copy with id 0, lowest bit first; the final event
// of a poll carries last. The sequencer issues one event per cycle from the
// pending-button mask while the output is not stalled, and takes the next
// poll only once the previous one is fully delivered. Polls with scanning
// disabled, or with no reportable change, finish in the request cycle.
// Configuration: index 0 scan_enable, 1 invert_mask, 2 ids of bits 0..3,
// 3 ids of bits 4..7 (16 bits each, lowest bit in the low sixteen); other
// indexes are ignored. Write only while idle.
// Depends on bsrs_pkg, bsrs_ctrl and bsrs_datapath.
module button_shift_register_scanner_core
    import bsrs_pkg::*;
#(
    parameter int NUM_BITS = NUM_BITS_DEF   // buttons scanned, clamped to 1..8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // poll requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEVEL_W-1:0]    raw_levels,
    // events
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  event_kind,
    output logic [ID_W-1:0]       button_id,
    output logic                  last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bsrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last      (last),
        .status    (status),
        .cmd       (cmd)
    );

    bsrs_datapath #(
        .NUM_BITS (NUM_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .raw_levels (raw_levels),
        .cmd        (cmd),
        .status     (status),
        .event_kind (event_kind),
        .button_id  (button_id)
    );

    // an event is only shown while some button is still pending
    a_valid_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status.pending)
        else $error("event shown with no pending button");

    // no new poll is taken while events are being delivered
    a_no_poll_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("poll accepted while events outstanding");

    // the final event of a poll is always an any-key copy
    a_last_is_any: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> (out_valid && button_id == '0))
        else $error("last flag on a non any-key event");

    // a taken event that is not final is followed by another event
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("event sequence broken before last");

endmodule
